// ===== design/pdh_pkg.sv =====
// Package for the pair distance histogram: controller states, action and
// register codes, and fixed field widths. No dependencies.
package pdh_pkg;

  localparam int COORD_W = 24;
  localparam int POINT_W = 2 * COORD_W;
  localparam int CFG_W = 23;
  localparam int COUNT_W = 32;
  localparam int PAIRS_W = 20;
  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W = 2 * DIFF_W;
  localparam int D2_W = SQ_W + 1;
  localparam int R2_W = 2 * CFG_W;
  localparam int ROOT_W = CFG_W;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int STEP_W = 5;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_READ = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_BIN = 1'b1;

  localparam logic REG_MAX_RADIUS = 1'b0;
  localparam logic REG_BIN_WIDTH = 1'b1;

  localparam logic [CFG_W-1:0] MAX_RADIUS_RST = 23'd2048;
  localparam logic [CFG_W-1:0] BIN_WIDTH_RST = 23'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RDBIN,
    S_FRAME,
    S_PTI,
    S_LATCHI,
    S_FETCHJ,
    S_DIFF,
    S_SQUARE,
    S_SUM,
    S_CMP,
    S_CALC,
    S_HRD,
    S_HWR,
    S_NEXTJ,
    S_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_SQRT,
    C_DIV
  } calc_state_t;

endpackage

// ===== design/pdh_ram.sv =====
// Single-port-write, single-port-read synchronous RAM, registered read.
// Depends on nothing; used for the point store and the histogram.
module pdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pdh_bin_calc.sv =====
// Iterative bin index unit: integer square root (two radicand bits a step)
// then restoring division by the bin width (one bit a step). Uses pdh_pkg.
module pdh_bin_calc (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pdh_pkg::R2_W-1:0]     radicand,
  input  logic [pdh_pkg::CFG_W-1:0]    divisor,
  output logic                         done,
  output logic [pdh_pkg::ROOT_W-1:0]   quotient
);

  pdh_pkg::calc_state_t phase, phase_next;
  logic [pdh_pkg::STEP_W-1:0] step;
  logic [pdh_pkg::R2_W-1:0] rad;
  logic [pdh_pkg::ROOT_W+2:0] rem_s;
  logic [pdh_pkg::ROOT_W-1:0] root;   // root, then dividend out / quotient in
  logic [pdh_pkg::CFG_W:0] rem_d;
  logic [pdh_pkg::CFG_W-1:0] div;
  logic last_step;

  logic [pdh_pkg::ROOT_W+2:0] rem_t, trial;
  logic sq_ge;
  logic [pdh_pkg::CFG_W:0] drem_t;
  logic dv_ge;

  assign last_step = (step == pdh_pkg::STEP_W'(pdh_pkg::ROOT_STEPS - 1));

  always_comb begin
    rem_t  = {rem_s[pdh_pkg::ROOT_W:0], rad[pdh_pkg::R2_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    sq_ge  = (rem_t >= trial);
    drem_t = {rem_d[pdh_pkg::CFG_W-1:0], root[pdh_pkg::ROOT_W-1]};
    dv_ge  = (drem_t >= {1'b0, div});
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      pdh_pkg::C_IDLE: if (start) phase_next = pdh_pkg::C_SQRT;
      pdh_pkg::C_SQRT: if (last_step) phase_next = pdh_pkg::C_DIV;
      pdh_pkg::C_DIV:  if (last_step) phase_next = pdh_pkg::C_IDLE;
      default:         phase_next = pdh_pkg::C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= pdh_pkg::C_IDLE;
      done <= 1'b0;
    end else begin
      phase <= phase_next;
      done <= (phase == pdh_pkg::C_DIV) && last_step;
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      pdh_pkg::C_IDLE: begin
        rad   <= radicand;
        rem_s <= '0;
        root  <= '0;
        div   <= divisor;
        step  <= '0;
      end
      pdh_pkg::C_SQRT: begin
        rad  <= rad << 2;
        rem_s <= sq_ge ? (rem_t - trial) : rem_t;
        root <= {root[pdh_pkg::ROOT_W-2:0], sq_ge};
        rem_d <= '0;
        step <= last_step ? '0 : step + 1'b1;
      end
      pdh_pkg::C_DIV: begin
        rem_d <= dv_ge ? (drem_t - {1'b0, div}) : drem_t;
        root  <= {root[pdh_pkg::ROOT_W-2:0], dv_ge};
        step  <= last_step ? '0 : step + 1'b1;
      end
      default: step <= '0;
    endcase
  end

  assign quotient = root;

endmodule

// ===== design/pair_distance_histogram.sv =====
// Top level of the pair distance histogram: controller, point store,
// histogram RAM and bin index unit. Uses pdh_pkg, pdh_ram, pdh_bin_calc.
//
//   channel | signals                                        | dir
//   --------+------------------------------------------------+-----
//   input   | in_valid/in_ready, action, x_coord, y_coord,   | in
//           | last_in_frame, bin_index                       |
//   result  | out_valid/out_ready, result_kind, bin_count,   | out
//           | pairs_counted, points_dropped                  |
//   config  | cfg_we, cfg_index, cfg_data (no wait)          | in
//
// An add that is not the last point, or a clear request, is accepted in idle;
// a clear then sweeps all NUM_BINS histogram bins. A bin read goes via its
// read state to the emit step. The last point starts the frame: per row,
// point i is read and latched; each pair is differenced, squared, summed and
// checked against the cutoff, and one inside it gets a square root and
// divide, one bit a cycle each, then, if its bin is in range, a histogram
// read-modify-write. Reset starts a histogram clearing pass; no beat is
// accepted until it ends, config writes are. A stalled result holds the
// controller in its emit step while the previous beat sits in the output.
module pair_distance_histogram #(
  parameter int MAX_POINTS = 1024,
  parameter int NUM_BINS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    action,
  input  logic signed [23:0]            x_coord,
  input  logic signed [23:0]            y_coord,
  input  logic                          last_in_frame,
  input  logic [9:0]                    bin_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_kind,
  output logic [31:0]                   bin_count,
  output logic [19:0]                   pairs_counted,
  output logic                          points_dropped,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [pdh_pkg::CFG_W-1:0]     cfg_data
);

  localparam int PAW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int HAW = $clog2(NUM_BINS);

  pdh_pkg::ctrl_state_t state, state_next;

  // configuration
  logic [pdh_pkg::CFG_W-1:0] max_radius, bin_width, w_eff;

  // frame bookkeeping
  logic [CW-1:0] point_count;
  logic overflow_flag;
  logic [CW-1:0] pair_i, pair_j;
  logic [pdh_pkg::POINT_W-1:0] pt_i;
  logic [pdh_pkg::DIFF_W-1:0] dx, dy;
  logic [pdh_pkg::SQ_W-1:0] dx2, dy2;
  logic [pdh_pkg::D2_W-1:0] d2;
  logic [pdh_pkg::R2_W-1:0] r2;
  logic [pdh_pkg::PAIRS_W-1:0] pairs;
  logic [HAW-1:0] bin_reg, clr_addr;
  logic res_kind, rd_in_range;
  logic [pdh_pkg::COUNT_W-1:0] res_count;

  // RAM ports
  logic pt_we;
  logic [PAW-1:0] pt_waddr, pt_raddr;
  logic [pdh_pkg::POINT_W-1:0] pt_wdata, pt_rdata;
  logic h_we;
  logic [HAW-1:0] h_waddr, h_raddr;
  logic [pdh_pkg::COUNT_W-1:0] h_wdata, h_rdata;

  // bin unit
  logic calc_start, calc_done;
  logic [pdh_pkg::ROOT_W-1:0] calc_q;

  logic accept, emit_free, q_in_range, idx_in_range;
  logic [31:0] idx_wide;
  logic signed [pdh_pkg::DIFF_W-1:0] ddx, ddy;

  assign w_eff = (bin_width == '0) ? pdh_pkg::CFG_W'(1) : bin_width;
  assign accept = in_valid && in_ready;
  assign emit_free = !out_valid || out_ready;
  assign idx_wide = 32'(bin_index);
  assign idx_in_range = idx_wide < 32'(NUM_BINS);
  assign q_in_range = 32'(calc_q) < 32'(NUM_BINS);

  // signed differences of the stored point i and the point j on the RAM port
  assign ddx = $signed({pt_rdata[pdh_pkg::POINT_W-1], pt_rdata[pdh_pkg::POINT_W-1 -: 24]})
             - $signed({pt_i[pdh_pkg::POINT_W-1], pt_i[pdh_pkg::POINT_W-1 -: 24]});
  assign ddy = $signed({pt_rdata[23], pt_rdata[23:0]}) - $signed({pt_i[23], pt_i[23:0]});

  pdh_ram #(.WIDTH(pdh_pkg::POINT_W), .DEPTH(MAX_POINTS)) u_points (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  pdh_ram #(.WIDTH(pdh_pkg::COUNT_W), .DEPTH(NUM_BINS)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  pdh_bin_calc u_calc (
    .clk(clk), .rst(rst), .start(calc_start),
    .radicand(d2[pdh_pkg::R2_W-1:0]), .divisor(w_eff),
    .done(calc_done), .quotient(calc_q)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pdh_pkg::S_CLEAR:
        if (clr_addr == HAW'(NUM_BINS - 1)) state_next = pdh_pkg::S_IDLE;
      pdh_pkg::S_IDLE:
        if (in_valid) begin
          unique case (action)
            pdh_pkg::ACT_ADD:   if (last_in_frame) state_next = pdh_pkg::S_FRAME;
            pdh_pkg::ACT_READ:  state_next = pdh_pkg::S_RDBIN;
            pdh_pkg::ACT_CLEAR: state_next = pdh_pkg::S_CLEAR;
            default:            state_next = pdh_pkg::S_IDLE;
          endcase
        end
      pdh_pkg::S_RDBIN:  state_next = pdh_pkg::S_EMIT;
      pdh_pkg::S_FRAME:
        state_next = (point_count < CW'(2)) ? pdh_pkg::S_EMIT : pdh_pkg::S_PTI;
      pdh_pkg::S_PTI:    state_next = pdh_pkg::S_LATCHI;
      pdh_pkg::S_LATCHI: state_next = pdh_pkg::S_DIFF;
      pdh_pkg::S_FETCHJ: state_next = pdh_pkg::S_DIFF;
      pdh_pkg::S_DIFF:   state_next = pdh_pkg::S_SQUARE;
      pdh_pkg::S_SQUARE: state_next = pdh_pkg::S_SUM;
      pdh_pkg::S_SUM:    state_next = pdh_pkg::S_CMP;
      pdh_pkg::S_CMP:
        state_next = (d2 < pdh_pkg::D2_W'(r2)) ? pdh_pkg::S_CALC : pdh_pkg::S_NEXTJ;
      pdh_pkg::S_CALC:
        if (calc_done) state_next = q_in_range ? pdh_pkg::S_HRD : pdh_pkg::S_NEXTJ;
      pdh_pkg::S_HRD:    state_next = pdh_pkg::S_HWR;
      pdh_pkg::S_HWR:    state_next = pdh_pkg::S_NEXTJ;
      pdh_pkg::S_NEXTJ:
        if ((CW + 1)'(pair_j) + 1'b1 < (CW + 1)'(point_count)) begin
          state_next = pdh_pkg::S_FETCHJ;
        end else if ((CW + 1)'(pair_i) + 2'd2 < (CW + 1)'(point_count)) begin
          state_next = pdh_pkg::S_PTI;
        end else begin
          state_next = pdh_pkg::S_EMIT;
        end
      pdh_pkg::S_EMIT:   if (emit_free) state_next = pdh_pkg::S_IDLE;
      default:           state_next = pdh_pkg::S_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_ready = (state == pdh_pkg::S_IDLE);
    calc_start = (state == pdh_pkg::S_CMP) && (d2 < pdh_pkg::D2_W'(r2));
    pt_we = accept && (action == pdh_pkg::ACT_ADD) && (point_count < CW'(MAX_POINTS));
    pt_waddr = point_count[PAW-1:0];
    pt_wdata = {x_coord, y_coord};
    pt_raddr = (state == pdh_pkg::S_PTI) ? pair_i[PAW-1:0] : pair_j[PAW-1:0];
    h_raddr = (state == pdh_pkg::S_IDLE) ? idx_wide[HAW-1:0] : bin_reg;
    h_we = (state == pdh_pkg::S_CLEAR) || (state == pdh_pkg::S_HWR);
    h_waddr = (state == pdh_pkg::S_CLEAR) ? clr_addr : bin_reg;
    h_wdata = (state == pdh_pkg::S_CLEAR) ? '0
            : (h_rdata == '1) ? h_rdata : h_rdata + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdh_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_radius <= pdh_pkg::MAX_RADIUS_RST;
      bin_width <= pdh_pkg::BIN_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pdh_pkg::REG_MAX_RADIUS: max_radius <= cfg_data;
        pdh_pkg::REG_BIN_WIDTH:  bin_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame control state
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      overflow_flag <= 1'b0;
      clr_addr <= '0;
    end else begin
      if (accept && action == pdh_pkg::ACT_ADD) begin
        if (point_count < CW'(MAX_POINTS)) point_count <= point_count + 1'b1;
        else overflow_flag <= 1'b1;
      end
      if (accept && action == pdh_pkg::ACT_CLEAR) clr_addr <= '0;
      else if (state == pdh_pkg::S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == pdh_pkg::S_EMIT && emit_free && res_kind == pdh_pkg::KIND_FRAME) begin
        point_count <= '0;
        overflow_flag <= 1'b0;
      end
    end
  end

  // pair datapath
  always_ff @(posedge clk) begin
    if (accept) rd_in_range <= idx_in_range;
    case (state)
      pdh_pkg::S_IDLE:   res_kind <= (action == pdh_pkg::ACT_READ)
                                     ? pdh_pkg::KIND_BIN : pdh_pkg::KIND_FRAME;
      pdh_pkg::S_RDBIN:  res_count <= rd_in_range ? h_rdata : '0;
      pdh_pkg::S_FRAME: begin
        r2 <= max_radius * max_radius;
        pairs <= '0;
        pair_i <= '0;
        pair_j <= CW'(1);
      end
      pdh_pkg::S_LATCHI: pt_i <= pt_rdata;
      pdh_pkg::S_DIFF: begin
        dx <= ddx[pdh_pkg::DIFF_W-1] ? pdh_pkg::DIFF_W'(-ddx) : pdh_pkg::DIFF_W'(ddx);
        dy <= ddy[pdh_pkg::DIFF_W-1] ? pdh_pkg::DIFF_W'(-ddy) : pdh_pkg::DIFF_W'(ddy);
      end
      pdh_pkg::S_SQUARE: begin
        dx2 <= dx * dx;
        dy2 <= dy * dy;
      end
      pdh_pkg::S_SUM:    d2 <= pdh_pkg::D2_W'(dx2) + pdh_pkg::D2_W'(dy2);
      pdh_pkg::S_CALC:   bin_reg <= calc_q[HAW-1:0];
      pdh_pkg::S_HWR:    if (pairs != '1) pairs <= pairs + 1'b1;
      pdh_pkg::S_NEXTJ: begin
        if ((CW + 1)'(pair_j) + 1'b1 < (CW + 1)'(point_count)) begin
          pair_j <= pair_j + 1'b1;
        end else begin
          pair_i <= pair_i + 1'b1;
          pair_j <= pair_i + CW'(2);
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == pdh_pkg::S_EMIT && emit_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pdh_pkg::S_EMIT && emit_free) begin
      result_kind <= res_kind;
      if (res_kind == pdh_pkg::KIND_BIN) begin
        bin_count <= res_count;
        pairs_counted <= '0;
        points_dropped <= 1'b0;
      end else begin
        bin_count <= '0;
        pairs_counted <= pairs;
        points_dropped <= overflow_flag;
      end
    end
  end

endmodule
